// ===== src/csum_pkg.sv =====
`default_nettype none

package csum_pkg;

  localparam int unsigned PosW = 17;
  localparam logic [PosW-1:0] PosMax = '1;
  localparam logic [PosW-1:0] HdrEnd = PosW'(20);
  localparam logic [PosW-3:0] SrcQuad = (PosW-2)'(3);
  localparam logic [PosW-3:0] DstQuad = (PosW-2)'(4);

  // Packet totals handed from the accumulator to the finishing stages
  typedef struct packed {
    logic [15:0]     sum;
    logic [7:0]      held;
    logic            odd;
    logic [31:0]     src;
    logic [31:0]     dst;
    logic [7:0]      proto;
    logic [15:0]     length;
    logic [PosW-1:0] seen;
    logic [PosW-1:0] stop;
  } final_t;

  // Ones' complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[15:0]} + {16'b0, s[16]};
    return f[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/internet_checksum_engine_top.sv =====
// Last byte to checksum: input, totals, partial-sum and result registers in turn.
// Throughput: one byte per cycle into the accumulator while no result waits untaken.
// A result waiting untaken holds the whole pipe, so in_ready falls with it.
// Reset (rst, synchronous, active high) empties the pipe; the next byte opens a packet.
`default_nettype none

module internet_checksum_engine_top
  import csum_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic [7:0]  proto_number,
  input  wire logic [15:0] skip_count,
  input  wire logic [15:0] sum_length,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      checksum,
  output logic             short_data,
  output logic             short_header
);

  logic   adv;
  logic   rec_valid;
  final_t rec;

  assign in_ready = adv;

  // Byte accumulator
  csum_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (in_valid),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .proto_number (proto_number),
    .skip_count   (skip_count),
    .sum_length   (sum_length),
    .rec_valid    (rec_valid),
    .rec          (rec)
  );

  // Pseudo-header add, fold and result register
  csum_final u_final (
    .clk          (clk),
    .rst          (rst),
    .rec_valid    (rec_valid),
    .rec          (rec),
    .adv          (adv),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .checksum     (checksum),
    .short_data   (short_data),
    .short_header (short_header)
  );

endmodule

`default_nettype wire

// ===== src/csum_accum.sv =====
`default_nettype none

module csum_accum
  import csum_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        adv,
  input  wire logic        in_valid,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic [7:0]  proto_number,
  input  wire logic [15:0] skip_count,
  input  wire logic [15:0] sum_length,
  output logic             rec_valid,
  output final_t           rec
);

  // Input register
  logic        a_valid;
  logic [7:0]  a_data;
  logic        a_last;
  logic [7:0]  a_proto;
  logic [15:0] a_skip;
  logic [15:0] a_length;

  // Per-packet state
  logic            in_packet;
  logic [PosW-1:0] pos;
  logic [15:0]     sum;
  logic [7:0]      held;
  logic            odd;
  logic [31:0]     src;
  logic [31:0]     dst;
  logic [7:0]      proto;
  logic [15:0]     skip;
  logic [15:0]     length;

  logic            first;
  logic [7:0]      proto_next;
  logic [15:0]     skip_next;
  logic [15:0]     length_next;
  logic [PosW-1:0] pos_cur;
  logic [PosW-1:0] pos_next;
  logic [PosW-1:0] stop;
  logic            in_range;
  logic [15:0]     sum_cur;
  logic [15:0]     sum_next;
  logic [7:0]      held_cur;
  logic [7:0]      held_next;
  logic            odd_cur;
  logic            odd_next;
  logic [31:0]     src_next;
  logic [31:0]     dst_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_data   <= data_byte;
      a_last   <= last_byte;
      a_proto  <= proto_number;
      a_skip   <= skip_count;
      a_length <= sum_length;
    end
  end

  // Start a fresh packet on the first byte: take its controls, clear totals
  always_comb begin
    first       = !in_packet;
    proto_next  = first ? a_proto : proto;
    skip_next   = first ? a_skip : skip;
    length_next = first ? a_length : length;
    pos_cur     = first ? '0 : pos;
    sum_cur     = first ? '0 : sum;
    held_cur    = first ? '0 : held;
    odd_cur     = first ? 1'b0 : odd;
    src_next    = first ? '0 : src;
    dst_next    = first ? '0 : dst;

    // Capture the addresses, high byte first
    if (pos_cur[PosW-1:2] == SrcQuad) begin
      src_next[8*(3-pos_cur[1:0]) +: 8] = a_data;
    end
    if (pos_cur[PosW-1:2] == DstQuad) begin
      dst_next[8*(3-pos_cur[1:0]) +: 8] = a_data;
    end

    // Pair bytes into big-endian words inside the summed range
    stop      = {1'b0, skip_next} + {1'b0, length_next};
    in_range  = (pos_cur >= {1'b0, skip_next}) && (pos_cur < stop);
    sum_next  = sum_cur;
    held_next = held_cur;
    odd_next  = odd_cur;
    if (in_range) begin
      if (!odd_cur) begin
        held_next = a_data;
        odd_next  = 1'b1;
      end else begin
        sum_next = oc_add(sum_cur, {held_cur, a_data});
        odd_next = 1'b0;
      end
    end

    // Saturate the position beyond the end of any summed range
    pos_next = (pos_cur == PosMax) ? pos_cur : pos_cur + PosW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet <= 1'b0;
    end else if (adv && a_valid) begin
      in_packet <= !a_last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && a_valid) begin
      pos    <= pos_next;
      sum    <= sum_next;
      held   <= held_next;
      odd    <= odd_next;
      src    <= src_next;
      dst    <= dst_next;
      proto  <= proto_next;
      skip   <= skip_next;
      length <= length_next;
    end
  end

  // Hand the packet totals on at the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (adv) begin
      rec_valid <= a_valid && a_last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rec.sum    <= sum_next;
      rec.held   <= held_next;
      rec.odd    <= odd_next;
      rec.src    <= src_next;
      rec.dst    <= dst_next;
      rec.proto  <= proto_next;
      rec.length <= length_next;
      rec.seen   <= pos_next;
      rec.stop   <= stop;
    end
  end

endmodule

`default_nettype wire

// ===== src/csum_final.sv =====
`default_nettype none

module csum_final
  import csum_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        rec_valid,
  input  wire final_t      rec,
  output logic             adv,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      checksum,
  output logic             short_data,
  output logic             short_header
);

  logic        d_valid;
  logic [17:0] d_part_a;
  logic [17:0] d_part_b;
  logic        d_short_data;
  logic        d_short_header;

  logic        pseudo;
  logic [17:0] part_a;
  logic [17:0] part_b;
  logic [18:0] total;
  logic [16:0] fold1;
  logic [16:0] fold2;

  // Advance the whole pipe unless a result waits untaken
  assign adv = !out_valid || out_ready;

  // Split the terms into two partial sums
  always_comb begin
    pseudo = (rec.proto != '0);
    part_a = {2'b0, rec.sum} + (rec.odd ? {2'b0, rec.held, 8'h00} : 18'd0);
    part_b = '0;
    if (pseudo) begin
      part_a = part_a + {2'b0, rec.src[31:16]} + {2'b0, rec.src[15:0]};
      part_b = {2'b0, rec.dst[31:16]} + {2'b0, rec.dst[15:0]} + {2'b0, rec.length}
             + {10'b0, rec.proto};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_part_a       <= part_a;
      d_part_b       <= part_b;
      d_short_data   <= (rec.seen < rec.stop);
      d_short_header <= pseudo && (rec.seen < HdrEnd);
    end
  end

  // Combine and fold the carries back in
  always_comb begin
    total = {1'b0, d_part_a} + {1'b0, d_part_b};
    fold1 = {1'b0, total[15:0]} + {14'b0, total[18:16]};
    fold2 = {1'b0, fold1[15:0]} + {16'b0, fold1[16]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      checksum     <= ~fold2[15:0];
      short_data   <= d_short_data;
      short_header <= d_short_header;
    end
  end

endmodule

`default_nettype wire

// ===== src/csum_checker.sv =====
`default_nettype none

module csum_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [7:0]  data_byte,
  input wire logic        last_byte,
  input wire logic [7:0]  proto_number,
  input wire logic [15:0] skip_count,
  input wire logic [15:0] sum_length,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] checksum,
  input wire logic        short_data,
  input wire logic        short_header
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(checksum)
      && $stable(short_data) && $stable(short_header))
    else $error("result changed while stalled");

  // Reset empties the result register
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Accept input whenever the result register is free
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with free result register");

  // Stall the input while a result waits
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

endmodule

bind internet_checksum_engine_top csum_checker u_chk (.*);

`default_nettype wire
